// ----- rtl/core/ppjs_pkg.sv -----
// shared types and constants for the priority job scheduler
`timescale 1ns / 1ps

package ppjs_pkg;

  localparam int ID_W        = 16;
  localparam int TIME_W      = 48;
  localparam int SVC_W       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RESULT_W    = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] rem;
  } entry_t;

  // queue operation for one cycle, at most one of pop, ins, charge is set
  typedef struct packed {
    logic             pop;
    logic             ins;
    logic             charge;
    entry_t           new_entry;
    logic [SVC_W-1:0] charge_rem;
  } cmd_t;

endpackage

// ----- rtl/core/ppjs_cell.sv -----
// one slot of the sorted job chain
`timescale 1ns / 1ps

module ppjs_cell (
  input  logic              clk,
  input  ppjs_pkg::cmd_t    cmd,
  input  logic              charge_en,
  input  logic              occ,
  input  logic              prev_gt,
  input  ppjs_pkg::entry_t  prev_entry,
  input  ppjs_pkg::entry_t  next_entry,
  output ppjs_pkg::entry_t  entry,
  output logic              gt
);

  // empty slots count as greater so the new job lands after the last occupied one
  assign gt = !occ || (entry.id > cmd.new_entry.id);

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      entry <= next_entry;
    end else if (cmd.ins && gt) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else begin
        entry <= cmd.new_entry;
      end
    end else if (cmd.charge && charge_en) begin
      entry.rem <= cmd.charge_rem;
    end
  end

endmodule

// ----- rtl/core/ppjs_chain.sv -----
// row of cells holding pending jobs sorted by id, best job in cell 0
`timescale 1ns / 1ps

module ppjs_chain #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  ppjs_pkg::cmd_t               cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output ppjs_pkg::entry_t             head
);

  localparam int CW = $clog2(DEPTH + 1);

  ppjs_pkg::entry_t entry_w [DEPTH];
  logic             gt_w    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             occ;
    logic             p_gt;
    ppjs_pkg::entry_t p_entry;
    ppjs_pkg::entry_t n_entry;

    assign occ = (count > CW'(i));

    if (i == 0) begin : g_first
      assign p_gt    = 1'b0;
      assign p_entry = '0;
    end else begin : g_mid
      assign p_gt    = gt_w[i-1];
      assign p_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_entry = '0;
    end else begin : g_inner
      assign n_entry = entry_w[i+1];
    end

    ppjs_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .charge_en  (i == 0),
      .occ        (occ),
      .prev_gt    (p_gt),
      .prev_entry (p_entry),
      .next_entry (n_entry),
      .entry      (entry_w[i]),
      .gt         (gt_w[i])
    );
  end

  assign head = entry_w[0];

endmodule

// ----- rtl/core/preemptive_priority_job_scheduler_core.sv -----
// preemptive priority job scheduler: sequencer, result staging and job chain
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------------
//  in      | in_valid / in_ready   | job_id, arrival_time, service_time, final_arrival
//  out     | out_valid / out_ready | done_job_id, finish_time, overflow, last_of_run
//
// an arrival passes idle, insert and finish on an empty queue, idle, complete, insert and
// finish otherwise, and drain before finish when final; complete and drain repeat for each
// completed or drained job, a dropped job needs no extra step, and a step that emits waits
// while the output side stalls. the sequencer handles one head pop or one sorted insert of
// the cell chain per cycle unless the output side stalls; each result is staged until the
// next result or the finish step moves it out, so the last one can carry last_of_run.
// in_ready is high only between arrivals; reset (rst, synchronous) empties the queue and clears the time.

`timescale 1ns / 1ps

module preemptive_priority_job_scheduler_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] job_id,
  input  logic [47:0] arrival_time,
  input  logic [31:0] service_time,
  input  logic        final_arrival,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] done_job_id,
  output logic [47:0] finish_time,
  output logic        overflow,
  output logic        last_of_run
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = ppjs_pkg::RESULT_W;
  localparam int TW = ppjs_pkg::TIME_W;
  localparam logic [NW-1:0] N_MAX  = NW'(ppjs_pkg::MAX_RESULTS);
  localparam logic [CW-1:0] Q_FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_COMPLETE = 5'b00010,
    S_INSERT   = 5'b00100,
    S_DRAIN    = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    pend_count, pend_count_next;
  logic [TW-1:0]    cur, cur_next;
  logic [TW-1:0]    delta, delta_next;
  logic [NW-1:0]    n_res, n_res_next;
  logic             arr_later, arr_later_next;
  logic [15:0]      nid;
  logic [47:0]      narr;
  logic [31:0]      nsvc;
  logic             nfin;

  logic             hold_valid, hold_valid_next;
  logic [15:0]      hold_id;
  logic [47:0]      hold_fin;
  logic             hold_ovf;

  ppjs_pkg::cmd_t   cmd;
  ppjs_pkg::entry_t head;

  logic             emit, emit_ok, flush, out_load;
  logic [15:0]      emit_id;
  logic [47:0]      emit_fin;
  logic             emit_ovf;
  logic [TW:0]      sum;
  logic [TW-1:0]    cur_sat;
  logic             head_done;

  ppjs_chain #(
    .DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (pend_count),
    .head  (head)
  );

  assign in_ready  = (state == S_IDLE);
  assign sum       = {1'b0, cur} + (TW+1)'(head.rem);
  assign cur_sat   = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign head_done = (pend_count != '0) && ({16'b0, head.rem} <= delta);
  // a new result may enter staging only if the staged one can move on
  assign emit_ok   = !hold_valid || !out_valid || out_ready;
  assign out_load  = (emit && hold_valid) || flush;

  always_comb begin
    state_next      = state;
    pend_count_next = pend_count;
    cur_next        = cur;
    delta_next      = delta;
    n_res_next      = n_res;
    arr_later_next  = arr_later;
    hold_valid_next = hold_valid;
    cmd             = '0;
    cmd.new_entry   = '{id: nid, rem: nsvc};
    cmd.charge_rem  = head.rem - delta[31:0];
    emit            = 1'b0;
    emit_id         = head.id;
    emit_fin        = cur_sat;
    emit_ovf        = 1'b0;
    flush           = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          n_res_next = '0;
          if (pend_count == '0) begin
            cur_next   = arrival_time;
            state_next = S_INSERT;
          end else begin
            arr_later_next = arrival_time > cur;
            delta_next     = (arrival_time > cur) ? arrival_time - cur : '0;
            state_next     = S_COMPLETE;
          end
        end
      end
      S_COMPLETE: begin
        if (head_done) begin
          if (n_res == N_MAX) begin
            // result limit: time stays at the last finish
            state_next = S_INSERT;
          end else if (emit_ok) begin
            emit            = 1'b1;
            cmd.pop         = 1'b1;
            pend_count_next = pend_count - CW'(1);
            delta_next      = delta - TW'(head.rem);
            cur_next        = cur_sat;
            n_res_next      = n_res + NW'(1);
          end
        end else begin
          cmd.charge = (pend_count != '0);
          if (arr_later) begin
            cur_next = narr;
          end
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        if (pend_count < Q_FULL) begin
          cmd.ins         = 1'b1;
          pend_count_next = pend_count + CW'(1);
          state_next      = nfin ? S_DRAIN : S_FINISH;
        end else if (n_res < N_MAX) begin
          if (emit_ok) begin
            emit       = 1'b1;
            emit_id    = nid;
            emit_fin   = '0;
            emit_ovf   = 1'b1;
            n_res_next = n_res + NW'(1);
            state_next = nfin ? S_DRAIN : S_FINISH;
          end
        end else begin
          state_next = nfin ? S_DRAIN : S_FINISH;
        end
      end
      S_DRAIN: begin
        if ((pend_count != '0) && (n_res < N_MAX)) begin
          if (emit_ok) begin
            emit            = 1'b1;
            cmd.pop         = 1'b1;
            pend_count_next = pend_count - CW'(1);
            cur_next        = cur_sat;
            n_res_next      = n_res + NW'(1);
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (!out_valid || out_ready) begin
          flush           = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (emit) begin
      hold_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_count <= '0;
      cur        <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_count <= pend_count_next;
      cur        <= cur_next;
      hold_valid <= hold_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    delta     <= delta_next;
    n_res     <= n_res_next;
    arr_later <= arr_later_next;
    if (in_valid && in_ready) begin
      nid  <= job_id;
      narr <= arrival_time;
      nsvc <= service_time;
      nfin <= final_arrival;
    end
    if (emit) begin
      hold_id  <= emit_id;
      hold_fin <= emit_fin;
      hold_ovf <= emit_ovf;
    end
    if (out_load) begin
      done_job_id <= hold_id;
      finish_time <= hold_fin;
      overflow    <= hold_ovf;
      last_of_run <= flush;
    end
  end

  a_idle_nothing_staged : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("result still staged while waiting for an arrival");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    pend_count <= Q_FULL)
    else $error("pending count beyond queue depth");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (pend_count != '0))
    else $error("pop from an empty queue");

  a_result_limit : assert property (@(posedge clk) disable iff (rst)
    emit |-> (n_res < N_MAX))
    else $error("too many results for one transaction");

endmodule

// ----- tb/preemptive_priority_job_scheduler_core_tb.sv -----
// self-checking testbench for the preemptive priority job scheduler core
`timescale 1ns / 1ps

module preemptive_priority_job_scheduler_core_tb;

  localparam int ID_W        = ppjs_pkg::ID_W;
  localparam int TIME_W      = ppjs_pkg::TIME_W;
  localparam int SVC_W       = ppjs_pkg::SVC_W;
  localparam int MAX_RESULTS = ppjs_pkg::MAX_RESULTS;

  localparam int QDEPTH     = 16;
  localparam int NDIR       = 26;
  localparam int RAND_ITEMS = 196;
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_MAX  = 3000;
  localparam int TAIL_WAIT  = 50;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] fin_t;
    logic              ovf;
    logic              last;
  } finish_rec_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arr;
    logic [SVC_W-1:0]  svc;
    logic              fin;
    logic              typed;
    logic [ID_W-1:0]   t_id;
    logic [TIME_W-1:0] t_fin;
    logic              t_ovf;
  } job_row_t;

  // directed rows; typed expectations only where the answer is obvious
  localparam job_row_t JOB_ROWS [NDIR] = '{
    '{16'h0005, 48'd0,       32'd0,          1'b1, 1'b1, 16'h0005, 48'd0, 1'b0},
    '{16'hFFFF, 48'd100,     32'hFFFF_FFFF,  1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0000, 48'd100,     32'd10,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0000, 48'd105,     32'd3,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0007, 48'd50,      32'd1,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0001, 48'd120,     32'd0,          1'b1, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0002, T_MAX - 5,   32'd100,        1'b1, 1'b1, 16'h0002, T_MAX, 1'b0},
    '{16'hFFFF, T_MAX,       32'd1,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0000, T_MAX,       32'hFFFF_FFFF,  1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h8000, T_MAX,       32'd7,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h1234, T_MAX,       32'd100,        1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0000, T_MAX,       32'd2,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'hFFFF, T_MAX,       32'd3,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h00FF, T_MAX,       32'd4,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h7FFF, T_MAX,       32'd5,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0010, T_MAX,       32'd6,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0010, T_MAX,       32'd8,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h4321, T_MAX,       32'd9,          1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0001, T_MAX,       32'd10,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'hAAAA, T_MAX,       32'd11,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h5555, T_MAX,       32'd12,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h0002, T_MAX,       32'd13,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'hFF00, T_MAX,       32'd14,         1'b0, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'hABCD, T_MAX,       32'd9,          1'b0, 1'b1, 16'hABCD, 48'd0, 1'b1},
    '{16'h0001, T_MAX,       32'd9,          1'b1, 1'b0, 16'h0,    48'd0, 1'b0},
    '{16'h5555, T_MAX,       32'd0,          1'b1, 1'b0, 16'h0,    48'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ID_W-1:0]   job_id = '0;
  logic [TIME_W-1:0] arrival_time = '0;
  logic [SVC_W-1:0]  service_time = '0;
  logic              final_arrival = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   done_job_id;
  logic [TIME_W-1:0] finish_time;
  logic              overflow;
  logic              last_of_run;

  // scheduler state as predicted
  ppjs_pkg::entry_t  sched_jobs [QDEPTH];
  int                sched_count = 0;
  logic [TIME_W-1:0] sched_now = '0;
  finish_rec_t       arrival_res [MAX_RESULTS];
  finish_rec_t       finish_q [$];

  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          bad_results = 0;
  int          quiet_cycles = 0;
  finish_rec_t got_rec;
  finish_rec_t want_rec;

  preemptive_priority_job_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .job_id       (job_id),
    .arrival_time (arrival_time),
    .service_time (service_time),
    .final_arrival(final_arrival),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .done_job_id  (done_job_id),
    .finish_time  (finish_time),
    .overflow     (overflow),
    .last_of_run  (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [SVC_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + b;
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  function automatic void pop_head();
    for (int i = 1; i < sched_count; i++) sched_jobs[i-1] = sched_jobs[i];
    if (sched_count > 0) sched_count--;
  endfunction

  // advances the predicted state by one arrival, results land in arrival_res
  function automatic int schedule_arrival(input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] arr,
                                          input logic [SVC_W-1:0] svc,
                                          input logic fin);
    logic [TIME_W-1:0] slack;
    int                n;
    int                pos;
    bit                capped;
    n = 0;
    capped = 0;
    if (sched_count == 0) begin
      sched_now = arr;
    end else begin
      slack = (arr > sched_now) ? arr - sched_now : '0;
      while (!capped && sched_count > 0 && sched_jobs[0].rem <= slack) begin
        if (n >= MAX_RESULTS) begin
          capped = 1;
        end else begin
          sched_now = sat_add(sched_now, sched_jobs[0].rem);
          arrival_res[n] = '{sched_jobs[0].id, sched_now, 1'b0, 1'b0};
          n++;
          slack = slack - sched_jobs[0].rem;
          pop_head();
        end
      end
      // the cap leaves the clock at the last finish, slack is reused later
      if (!capped) begin
        if (sched_count > 0) sched_jobs[0].rem = sched_jobs[0].rem - slack[SVC_W-1:0];
        if (arr > sched_now) sched_now = arr;
      end
    end
    if (sched_count < QDEPTH) begin
      pos = sched_count;
      while (pos > 0 && sched_jobs[pos-1].id > id) begin
        sched_jobs[pos] = sched_jobs[pos-1];
        pos--;
      end
      sched_jobs[pos].id = id;
      sched_jobs[pos].rem = svc;
      sched_count++;
    end else if (n < MAX_RESULTS) begin
      arrival_res[n] = '{id, {TIME_W{1'b0}}, 1'b1, 1'b0};
      n++;
    end
    if (fin) begin
      while (sched_count > 0 && n < MAX_RESULTS) begin
        sched_now = sat_add(sched_now, sched_jobs[0].rem);
        arrival_res[n] = '{sched_jobs[0].id, sched_now, 1'b0, 1'b0};
        n++;
        pop_head();
      end
    end
    if (n > 0) arrival_res[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(3) == 0) ? ID_W'($urandom_range(0, 65535))
                                    : ID_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [SVC_W-1:0] pick_svc();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      default: return SVC_W'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0:       return T_MAX - $urandom_range(0, 2000);
      1, 2:    return TIME_W'({$urandom, $urandom});
      default: return TIME_W'($urandom_range(0, 100000));
    endcase
  endfunction

  // offers one arrival, waits for its transaction and queues what it must cause
  task automatic offer_job(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
                           input logic [SVC_W-1:0] svc, input logic fin,
                           input logic typed, input finish_rec_t typed_rec);
    int n;
    if (items_sent < 90) begin
      send_idle_pct = 0;
      stall_pct <= 0;
    end else if (items_sent < 150) begin
      send_idle_pct = 85;
      stall_pct <= 0;
    end else if (items_sent < 210) begin
      send_idle_pct = 0;
      stall_pct <= 85;
    end else begin
      send_idle_pct = 8;
      stall_pct <= 8;
    end
    if (items_sent == 60) hold_req <= 1'b1;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    job_id        <= id;
    arrival_time  <= arr;
    service_time  <= svc;
    final_arrival <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = schedule_arrival(id, arr, svc, fin);
    if (typed) finish_q.push_back(typed_rec);
    else for (int k = 0; k < n; k++) finish_q.push_back(arrival_res[k]);
    items_sent++;
  endtask

  initial begin
    int                kind;
    int                njobs;
    logic [TIME_W-1:0] t;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < NDIR; r++) begin
      offer_job(JOB_ROWS[r].id, JOB_ROWS[r].arr, JOB_ROWS[r].svc, JOB_ROWS[r].fin,
                JOB_ROWS[r].typed,
                '{JOB_ROWS[r].t_id, JOB_ROWS[r].t_fin, JOB_ROWS[r].t_ovf, 1'b1});
    end
    while (items_sent < NDIR + RAND_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70 || kind >= 95) begin
        // a run of arrivals in time order (the time may wrap near the top), closed by a drain unless left open
        njobs = $urandom_range(1, 12);
        t = pick_time();
        for (int j = 0; j < njobs; j++) begin
          if ($urandom_range(3) != 0) t = t + $urandom_range(0, 40);
          offer_job(pick_id(), t, pick_svc(), (j == njobs - 1) && (kind < 95), 1'b0, '0);
        end
      end else if (kind < 82) begin
        // burst at one tick that overruns the queue
        njobs = $urandom_range(17, 19);
        t = pick_time();
        for (int j = 0; j < njobs; j++) begin
          offer_job(pick_id(), t, SVC_W'($urandom_range(1, 50)), j == njobs - 1, 1'b0, '0);
        end
      end else begin
        // noise: arbitrary fields, time may go backwards
        njobs = $urandom_range(1, 4);
        for (int j = 0; j < njobs; j++) begin
          offer_job(ID_W'($urandom), TIME_W'({$urandom, $urandom}), $urandom,
                    1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;
    while (finish_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (bad_results == 0) begin
      $display("preemptive_priority_job_scheduler_core test passed");
    end else begin
      $display("preemptive_priority_job_scheduler_core test failed");
    end
    $finish;
  end

  // result side: check each transaction, then pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_rec = '{done_job_id, finish_time, overflow, last_of_run};
      if (finish_q.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: id %h finish %h ovf %b last %b",
                   got_rec.id, got_rec.fin_t, got_rec.ovf, got_rec.last);
        bad_results++;
      end else begin
        want_rec = finish_q.pop_front();
        if (got_rec.id !== want_rec.id || got_rec.fin_t !== want_rec.fin_t ||
            got_rec.ovf !== want_rec.ovf || got_rec.last !== want_rec.last) begin
          if (bad_results < 10)
            $display({"mismatch: exp id %h finish %h ovf %b last %b, ",
                      "got id %h finish %h ovf %b last %b"},
                     want_rec.id, want_rec.fin_t, want_rec.ovf, want_rec.last,
                     got_rec.id, got_rec.fin_t, got_rec.ovf, got_rec.last);
          bad_results++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("preemptive_priority_job_scheduler_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/ppjs_pkg.sv
rtl/core/ppjs_cell.sv
rtl/core/ppjs_chain.sv
rtl/core/preemptive_priority_job_scheduler_core.sv
tb/preemptive_priority_job_scheduler_core_tb.sv
